[rtl/tccw_pkg.sv]
`default_nettype none

package tccw_pkg;

    // cells between the starts of two screen rows
    localparam int ROW_STRIDE = 80;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_PRESENT = 3'd0;
    localparam logic [2:0] REG_WIDTH   = 3'd1;
    localparam logic [2:0] REG_LASTROW = 3'd2;
    localparam logic [2:0] REG_PAGE    = 3'd3;
    localparam logic [2:0] REG_PORT    = 3'd4;
    localparam logic [2:0] REG_ATTR    = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_CELL  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_PORT  = 2'd2;
    localparam logic [1:0] KIND_SAVE  = 2'd3;

    // character codes and crtc register indexes
    localparam logic [7:0] CHAR_LF     = 8'd10;
    localparam logic [7:0] CHAR_CR     = 8'd13;
    localparam logic [7:0] CHAR_SPACE  = 8'd32;
    localparam logic [7:0] CRTC_CUR_HI = 8'h0e;
    localparam logic [7:0] CRTC_CUR_LO = 8'h0f;

    // page size is rounded up past the low byte
    localparam logic [13:0] SPAN_ROUND = 14'h00ff;

    typedef struct packed {
        logic        present;
        logic [6:0]  width;
        logic [5:0]  last_row;
        logic [2:0]  page;
        logic [15:0] port;
        logic [7:0]  attr;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        present:  1'b1,
        width:    7'd80,
        last_row: 6'd24,
        page:     3'd0,
        port:     16'd980,
        attr:     8'd7
    };

endpackage

`default_nettype wire

[rtl/tccw_regs.sv]
`default_nettype none

module tccw_regs
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tccw_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tccw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [tccw_pkg::APB_DATA_W-1:0]  prdata,
    output tccw_pkg::cfg_t                        cfg,
    output logic      [15:0]                      page_base,
    output logic                                  cfg_wr
);
    import tccw_pkg::*;

    cfg_t        cfg_reg;
    logic [2:0]  reg_sel;
    logic [6:0]  rows;
    logic [13:0] area;
    logic [14:0] span;
    logic [14:0] span_reg;
    logic [17:0] base_full;
    logic [15:0] base_reg;

    assign reg_sel = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_PRESENT: cfg_reg.present  <= pwdata[0];
                REG_WIDTH:   cfg_reg.width    <= pwdata[6:0];
                REG_LASTROW: cfg_reg.last_row <= pwdata[5:0];
                REG_PAGE:    cfg_reg.page     <= pwdata[2:0];
                REG_PORT:    cfg_reg.port     <= pwdata[15:0];
                REG_ATTR:    cfg_reg.attr     <= pwdata[7:0];
                default:     cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_sel)
            REG_PRESENT: prdata = {31'd0, cfg_reg.present};
            REG_WIDTH:   prdata = {25'd0, cfg_reg.width};
            REG_LASTROW: prdata = {26'd0, cfg_reg.last_row};
            REG_PAGE:    prdata = {29'd0, cfg_reg.page};
            REG_PORT:    prdata = {16'd0, cfg_reg.port};
            REG_ATTR:    prdata = {24'd0, cfg_reg.attr};
            default:     prdata = '0;
        endcase
    end

    // page size, then page offset, one multiply per stage
    assign rows      = {1'b0, cfg_reg.last_row} + 7'd1;
    assign area      = {7'd0, cfg_reg.width} * {7'd0, rows};
    assign span      = {1'b0, area | SPAN_ROUND} + 15'd1;
    assign base_full = {3'd0, span_reg} * {15'd0, cfg_reg.page};

    always_ff @(posedge clk)
    begin
        span_reg <= span;
        base_reg <= base_full[15:0];
    end

    assign cfg       = cfg_reg;
    assign page_base = base_reg;

endmodule

`default_nettype wire

[rtl/text_console_cursor_writer.sv]
// a character goes through the input register, the result descriptor and the output register
// throughput: one character per cycle while each gives a single cell write and the output is
//   not stalled; a character with several results holds the input until its last word is sent,
//   one result word per cycle at m_* while m_tready is high; input is held off after reset
//   and each register write, longer while a cursor left outside a shrunk screen is reduced
// reset: asynchronous active low, cursor at row 0 column 0, registers at their defaults
`default_nettype none

module text_console_cursor_writer
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input words
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // char_code
    // result words
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [31:0]                      m_tdata,   // address, data
    output logic      [1:0]                       m_tuser,   // kind
    output logic                                  m_tlast,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tccw_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tccw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [tccw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import tccw_pkg::*;

    // result slots of one descriptor, in the order they go out
    localparam logic [2:0] SLOT_CELL   = 3'd0;
    localparam logic [2:0] SLOT_CLEAR  = 3'd1;
    localparam logic [2:0] SLOT_SAVE   = 3'd2;
    localparam logic [2:0] SLOT_IDX_HI = 3'd3;
    localparam logic [2:0] SLOT_DAT_HI = 3'd4;
    localparam logic [2:0] SLOT_IDX_LO = 3'd5;
    localparam logic [2:0] SLOT_DAT_LO = 3'd6;

    cfg_t        cfg;
    logic [15:0] page_base;
    logic        cfg_wr;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;

    // cursor state, raw and reduced to the current screen
    logic [6:0]  col_reg;
    logic [5:0]  row_reg;
    logic [15:0] cell_reg;
    logic [6:0]  cm_reg;
    logic [5:0]  rm_reg;
    logic        mods_ok_reg;

    // result descriptor
    logic        d_valid_reg;
    logic [2:0]  d_slot_reg;
    logic        d_clear_reg;
    logic        d_burst_reg;
    logic [15:0] d_addr_reg;
    logic [7:0]  d_char_reg;
    logic [15:0] d_cur_reg;

    // output register
    logic        m_tvalid_reg;
    logic [1:0]  o_kind_reg;
    logic [15:0] o_addr_reg;
    logic [15:0] o_data_reg;
    logic        o_last_reg;

    // step logic
    logic [6:0]  width_eff;
    logic [6:0]  rows;
    logic        is_print;
    logic        is_lf;
    logic        is_cr;
    logic [7:0]  col_inc;
    logic        wrap;
    logic [7:0]  cm_inc;
    logic [6:0]  cm_wrap;
    logic [6:0]  row_inc;
    logic        row_over;
    logic [6:0]  rm_inc;
    logic [5:0]  rm_step;
    logic [6:0]  ncol;
    logic [5:0]  nrow;
    logic [6:0]  ncm;
    logic [5:0]  nrm;
    logic [15:0] ncell;
    logic [15:0] line_index;
    logic [15:0] ncur;
    logic        has_cell;
    logic        has_clear;
    logic        has_burst;

    // flow control
    logic        o_load;
    logic        d_emit;
    logic        d_done;
    logic        d_free;
    logic        proc;
    logic        s_acc;
    logic [2:0]  slot_next;
    logic        slot_last;
    logic [1:0]  slot_kind;
    logic [15:0] slot_addr;
    logic [15:0] slot_data;
    logic [15:0] dport;

    tccw_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .cfg       (cfg),
        .page_base (page_base),
        .cfg_wr    (cfg_wr)
    );

    assign pready = 1'b1;

    // screen geometry
    assign width_eff = (cfg.width == 7'd0) ? 7'd1 : cfg.width;
    assign rows      = {1'b0, cfg.last_row} + 7'd1;

    // character decode
    assign is_print = in_char_reg >= CHAR_SPACE;
    assign is_lf    = in_char_reg == CHAR_LF;
    assign is_cr    = in_char_reg == CHAR_CR;

    // column and row steps
    assign col_inc  = {1'b0, col_reg} + 8'd1;
    assign wrap     = col_inc >= {1'b0, width_eff};
    assign cm_inc   = {1'b0, cm_reg} + 8'd1;
    assign cm_wrap  = (cm_inc == {1'b0, width_eff}) ? 7'd0 : cm_inc[6:0];
    assign row_inc  = {1'b0, row_reg} + 7'd1;
    assign row_over = row_inc >= rows;
    assign rm_inc   = {1'b0, rm_reg} + 7'd1;
    assign rm_step  = (rm_inc == rows) ? 6'd0 : rm_inc[5:0];

    // next cursor state and results of the character in the input register
    always_comb
    begin
        ncol      = col_reg;
        nrow      = row_reg;
        ncm       = cm_reg;
        nrm       = rm_reg;
        ncell     = cell_reg;
        has_cell  = 1'b0;
        has_clear = 1'b0;
        has_burst = 1'b0;
        if (cfg.present)
        begin
            if (is_print)
            begin
                has_cell = 1'b1;
                ncell    = cell_reg + 16'd1;
                if (wrap)
                begin
                    ncol      = cm_wrap;
                    nrow      = row_over ? 6'd0 : row_inc[5:0];
                    has_clear = row_over;
                    has_burst = 1'b1;
                end
                else
                begin
                    ncol = col_inc[6:0];
                    ncm  = col_inc[6:0];
                end
            end
            else if (is_lf)
            begin
                ncol      = cm_reg;
                nrow      = rm_step;
                has_burst = 1'b1;
            end
            else if (is_cr)
            begin
                ncol      = 7'd0;
                nrow      = rm_reg;
                has_burst = 1'b1;
            end
        end
        line_index = 16'(nrow) * 16'(ROW_STRIDE) + 16'(ncol);
        ncur       = page_base + line_index;
        if (has_burst)
        begin
            ncm   = ncol;
            nrm   = nrow;
            ncell = line_index;
        end
    end

    // sequence of result slots in a descriptor
    always_comb
    begin
        slot_next = d_slot_reg;
        slot_last = 1'b0;
        unique case (d_slot_reg)
            SLOT_CELL:
            begin
                if (d_clear_reg)
                    slot_next = SLOT_CLEAR;
                else if (d_burst_reg)
                    slot_next = SLOT_SAVE;
                else
                    slot_last = 1'b1;
            end
            SLOT_CLEAR:  slot_next = SLOT_SAVE;
            SLOT_SAVE:   slot_next = SLOT_IDX_HI;
            SLOT_IDX_HI: slot_next = SLOT_DAT_HI;
            SLOT_DAT_HI: slot_next = SLOT_IDX_LO;
            SLOT_IDX_LO: slot_next = SLOT_DAT_LO;
            default:     slot_last = 1'b1;
        endcase
    end

    // payload of the current slot
    assign dport = cfg.port + 16'd1;

    always_comb
    begin
        case (d_slot_reg)
            SLOT_CELL:
            begin
                slot_kind = KIND_CELL;
                slot_addr = d_addr_reg;
                slot_data = {cfg.attr, d_char_reg};
            end
            SLOT_CLEAR:
            begin
                slot_kind = KIND_CLEAR;
                slot_addr = 16'd0;
                slot_data = {cfg.attr, 8'd0};
            end
            SLOT_SAVE:
            begin
                slot_kind = KIND_SAVE;
                slot_addr = {13'd0, cfg.page};
                slot_data = d_cur_reg;
            end
            SLOT_IDX_HI:
            begin
                slot_kind = KIND_PORT;
                slot_addr = cfg.port;
                slot_data = {8'd0, CRTC_CUR_HI};
            end
            SLOT_DAT_HI:
            begin
                slot_kind = KIND_PORT;
                slot_addr = dport;
                slot_data = {8'd0, d_cur_reg[15:8]};
            end
            SLOT_IDX_LO:
            begin
                slot_kind = KIND_PORT;
                slot_addr = cfg.port;
                slot_data = {8'd0, CRTC_CUR_LO};
            end
            default:
            begin
                slot_kind = KIND_PORT;
                slot_addr = dport;
                slot_data = {8'd0, d_cur_reg[7:0]};
            end
        endcase
    end

    // handshake between stages
    assign o_load   = !m_tvalid_reg || m_tready;
    assign d_emit   = d_valid_reg && o_load;
    assign d_done   = d_emit && slot_last;
    assign d_free   = !d_valid_reg || d_done;
    assign proc     = in_valid_reg && d_free;
    assign s_tready = mods_ok_reg && (!in_valid_reg || d_free);
    assign s_acc    = s_tvalid && s_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_acc)
            in_valid_reg <= 1'b1;
        else if (proc)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
            in_char_reg <= s_tdata;
    end

    // cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= 7'd0;
            row_reg  <= 6'd0;
            cell_reg <= 16'd0;
        end
        else if (proc)
        begin
            col_reg  <= ncol;
            row_reg  <= nrow;
            cell_reg <= ncell;
        end
    end

    // cursor reduced modulo the screen, recomputed by subtraction after a register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cm_reg      <= 7'd0;
            rm_reg      <= 6'd0;
            mods_ok_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            cm_reg      <= col_reg;
            rm_reg      <= row_reg;
            mods_ok_reg <= 1'b0;
        end
        else if (!mods_ok_reg)
        begin
            if (cm_reg >= width_eff)
                cm_reg <= cm_reg - width_eff;
            if ({1'b0, rm_reg} >= rows)
                rm_reg <= rm_reg - rows[5:0];
            mods_ok_reg <= (cm_reg < width_eff) && ({1'b0, rm_reg} < rows);
        end
        else if (proc)
        begin
            cm_reg <= ncm;
            rm_reg <= nrm;
        end
    end

    // descriptor control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            d_slot_reg  <= SLOT_CELL;
        end
        else if (proc && (has_cell || has_burst))
        begin
            d_valid_reg <= 1'b1;
            d_slot_reg  <= has_cell ? SLOT_CELL : SLOT_SAVE;
        end
        else if (d_done)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (d_emit)
        begin
            d_slot_reg <= slot_next;
        end
    end

    // descriptor payload
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            d_clear_reg <= has_clear;
            d_burst_reg <= has_burst;
            d_addr_reg  <= cell_reg;
            d_char_reg  <= in_char_reg;
            d_cur_reg   <= ncur;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (o_load)
            m_tvalid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (d_emit)
        begin
            o_kind_reg <= slot_kind;
            o_addr_reg <= slot_addr;
            o_data_reg <= slot_data;
            o_last_reg <= slot_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {o_data_reg, o_addr_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import tccw_pkg::*;

    localparam int LIMIT_CYCLES     = 200000;
    localparam int DRAIN_CYCLES     = 140;
    localparam int HOLD_CYCLES      = 300;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 17;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int MAX_GAP          = 12;

    // one result word as the block emits it
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [15:0] data;
        logic        last;
    } console_word_t;

    // directed stimulus: either a register write or a character,
    // a character may carry a single typed-in result word
    typedef struct packed {
        logic        is_reg;
        logic [2:0]  reg_idx;
        logic [15:0] value;
        logic        fixed;
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [15:0] data;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 37;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // defaults after reset, extremes of the character code
        '{1'b0, '0, 16'h0041, 1'b1, KIND_CELL, 16'd0, 16'h0741},
        '{1'b0, '0, 16'h00ff, 1'b1, KIND_CELL, 16'd1, 16'h07ff},
        '{1'b0, '0, 16'h0020, 1'b1, KIND_CELL, 16'd2, 16'h0720},
        // ignored control codes
        '{1'b0, '0, 16'h0000, 1'b0, '0, '0, '0},
        '{1'b0, '0, 16'h001f, 1'b0, '0, '0, '0},
        // line feed, carriage return
        '{1'b0, '0, {8'h00, CHAR_LF}, 1'b0, '0, '0, '0},
        '{1'b0, '0, {8'h00, CHAR_CR}, 1'b0, '0, '0, '0},
        // full attribute byte
        '{1'b1, REG_ATTR, 16'h00ff, 1'b0, '0, '0, '0},
        '{1'b0, '0, 16'h0020, 1'b1, KIND_CELL, 16'd80, 16'hff20},
        '{1'b0, '0, 16'h0080, 1'b0, '0, '0, '0},
        // one-row screen two columns wide, last page, data port at the top address
        '{1'b1, REG_WIDTH, 16'd2, 1'b0, '0, '0, '0},
        '{1'b1, REG_LASTROW, 16'd0, 1'b0, '0, '0, '0},
        '{1'b1, REG_PAGE, 16'd7, 1'b0, '0, '0, '0},
        '{1'b1, REG_PORT, 16'hfffe, 1'b0, '0, '0, '0},
        '{1'b0, '0, 16'h0078, 1'b0, '0, '0, '0},
        '{1'b0, '0, 16'h0079, 1'b0, '0, '0, '0},
        // zero width behaves as one column
        '{1'b1, REG_WIDTH, 16'd0, 1'b0, '0, '0, '0},
        '{1'b0, '0, 16'h007a, 1'b0, '0, '0, '0},
        // no display: everything ignored
        '{1'b1, REG_PRESENT, 16'd0, 1'b0, '0, '0, '0},
        '{1'b0, '0, 16'h0071, 1'b0, '0, '0, '0},
        '{1'b0, '0, {8'h00, CHAR_LF}, 1'b0, '0, '0, '0},
        '{1'b1, REG_PRESENT, 16'd1, 1'b0, '0, '0, '0},
        // 80 by 50 screen, move the cursor down and right
        '{1'b1, REG_WIDTH, 16'd80, 1'b0, '0, '0, '0},
        '{1'b1, REG_LASTROW, 16'd49, 1'b0, '0, '0, '0},
        '{1'b1, REG_PAGE, 16'd0, 1'b0, '0, '0, '0},
        '{1'b1, REG_PORT, 16'd0, 1'b0, '0, '0, '0},
        '{1'b0, '0, {8'h00, CHAR_LF}, 1'b0, '0, '0, '0},
        '{1'b0, '0, {8'h00, CHAR_LF}, 1'b0, '0, '0, '0},
        '{1'b0, '0, {8'h00, CHAR_LF}, 1'b0, '0, '0, '0},
        '{1'b0, '0, 16'h0061, 1'b0, '0, '0, '0},
        '{1'b0, '0, 16'h0062, 1'b0, '0, '0, '0},
        '{1'b0, '0, 16'h0063, 1'b0, '0, '0, '0},
        '{1'b0, '0, 16'h0064, 1'b0, '0, '0, '0},
        // shrink the screen under the cursor
        '{1'b1, REG_WIDTH, 16'd3, 1'b0, '0, '0, '0},
        '{1'b1, REG_LASTROW, 16'd1, 1'b0, '0, '0, '0},
        '{1'b0, '0, {8'h00, CHAR_LF}, 1'b0, '0, '0, '0},
        '{1'b0, '0, 16'h007f, 1'b0, '0, '0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // typed-in expectation travels beside the character it belongs to
    logic                  fixed_valid = 1'b0;
    console_word_t         fixed_word = '0;

    // console model state
    cfg_t                  cfg = CFG_RESET;
    int                    cur_col = 0;
    int                    cur_row = 0;
    int                    cur_cell = 0;
    console_word_t         step_words[$];
    console_word_t         pending_words[$];

    int                    fail_count = 0;
    int                    cycle_count = 0;
    int                    sender_idle_pct = 30;
    int                    receiver_idle_pct = 0;
    bit                    hold_toggle = 1'b0;

    text_console_cursor_writer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOWN_MISMATCHES)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic void add_word(input logic [1:0] kind, input int addr, input int data);
        step_words.push_back({kind, addr[15:0], data[15:0], 1'b0});
    endfunction

    // cursor save followed by the four crtc writes
    function automatic void cursor_burst();
        int span;
        int cur;
        int dport;
        span  = ((int'(cfg.width) * (int'(cfg.last_row) + 1)) | 'hff) + 1;
        cur   = (span * int'(cfg.page) + cur_row * ROW_STRIDE + cur_col) & 'hffff;
        dport = (int'(cfg.port) + 1) & 'hffff;
        add_word(KIND_SAVE, int'(cfg.page), cur);
        add_word(KIND_PORT, int'(cfg.port), int'(CRTC_CUR_HI));
        add_word(KIND_PORT, dport, cur >> 8);
        add_word(KIND_PORT, int'(cfg.port), int'(CRTC_CUR_LO));
        add_word(KIND_PORT, dport, cur & 'hff);
    endfunction

    // words caused by one character, left in step_words
    function automatic void console_step(input logic [7:0] ch);
        int w;
        int rows;
        w    = (cfg.width == 0) ? 1 : int'(cfg.width);
        rows = int'(cfg.last_row) + 1;
        step_words.delete();
        if (!cfg.present)
            return;
        if (ch >= CHAR_SPACE)
        begin
            add_word(KIND_CELL, cur_cell, {cfg.attr, ch});
            cur_cell = (cur_cell + 1) & 'hffff;
            cur_col++;
            if (cur_col >= w)
            begin
                cur_col = cur_col % w;
                cur_row++;
                // past the last row: back to the top with a clear
                if (cur_row >= rows)
                begin
                    cur_row = 0;
                    add_word(KIND_CLEAR, 0, {cfg.attr, 8'h00});
                end
                cur_cell = (cur_row * ROW_STRIDE + cur_col) & 'hffff;
                cursor_burst();
            end
            else
                cur_col &= 'h7f;
        end
        else if (ch == CHAR_LF)
        begin
            cur_col  = cur_col % w;
            cur_row  = (cur_row + 1) % rows;
            cur_cell = (cur_row * ROW_STRIDE + cur_col) & 'hffff;
            cursor_burst();
        end
        else if (ch == CHAR_CR)
        begin
            cur_col  = 0;
            cur_row  = cur_row % rows;
            cur_cell = (cur_row * ROW_STRIDE + cur_col) & 'hffff;
            cursor_burst();
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
    endfunction

    // check result words, predict on accepted characters
    always @(posedge clk)
    begin
        console_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_words.size() == 0)
                    note_failure($sformatf("unexpected word: kind %0d addr %h data %h last %b",
                        m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast));
                else
                begin
                    want = pending_words.pop_front();
                    if (m_tuser !== want.kind || m_tdata[15:0] !== want.addr ||
                        m_tdata[31:16] !== want.data || m_tlast !== want.last)
                        note_failure($sformatf({"word mismatch: expected kind %0d addr %h ",
                            "data %h last %b, got kind %0d addr %h data %h last %b"},
                            want.kind, want.addr, want.data, want.last,
                            m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast));
                end
            end
            if (s_tvalid && s_tready)
            begin
                console_step(s_tdata);
                if (fixed_valid)
                    pending_words.push_back(fixed_word);
                else
                    foreach (step_words[i])
                        pending_words.push_back(step_words[i]);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic fixed, input console_word_t word);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= ch;
        fixed_valid <= fixed;
        fixed_word  <= word;
        do @(posedge clk); while (!s_tready);
    endtask

    // let every expected word out, then allow the block to settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        // the checker has taken the last accepted character by the next edge
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, then read it back
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_PRESENT: cfg.present  = val[0];
            REG_WIDTH:   cfg.width    = val[6:0];
            REG_LASTROW: cfg.last_row = val[5:0];
            REG_PAGE:    cfg.page     = val[2:0];
            REG_PORT:    cfg.port     = val[15:0];
            REG_ATTR:    cfg.attr     = val[7:0];
            default: ;
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== val)
            note_failure($sformatf("register %0d read back %h, expected %h", idx, prdata, val));
        psel    <= 1'b0;
        penable <= 1'b0;
        // bus returns to idle between transfers
        @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int r;
        logic [7:0] ch;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        receiver_idle_pct <= 70;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].is_reg)
            begin
                wait_drained();
                write_reg(DIRECTED[i].reg_idx, 32'(DIRECTED[i].value));
            end
            else
                send_char(DIRECTED[i].value[7:0], DIRECTED[i].fixed,
                    {DIRECTED[i].kind, DIRECTED[i].addr, DIRECTED[i].data, 1'b1});
        end

        // random phases, each with fresh settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            if (p < 3)
            begin
                sender_idle_pct = 30;
                receiver_idle_pct <= 70;
            end
            else if (p < 6)
            begin
                sender_idle_pct = 70;
                receiver_idle_pct <= 30;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_idle_pct <= 0;
            end

            write_reg(REG_PRESENT, 32'($urandom_range(0, 9) != 0));
            r = $urandom_range(0, 9);
            write_reg(REG_WIDTH, (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 80 :
                (r == 3) ? $urandom_range(1, 80) : $urandom_range(2, 12));
            r = $urandom_range(0, 9);
            write_reg(REG_LASTROW, (r == 0) ? 0 : (r == 1) ? 49 :
                (r < 4) ? $urandom_range(0, 49) : $urandom_range(0, 5));
            write_reg(REG_PAGE, $urandom_range(0, 7));
            r = $urandom_range(0, 9);
            write_reg(REG_PORT, (r == 0) ? 0 : (r == 1) ? 'hfffe : (r == 2) ? 'hffff :
                $urandom_range(0, 'hffff));
            write_reg(REG_ATTR, $urandom_range(0, 255));

            // long output hold-off while characters keep coming
            if (p == 1 || p == 6)
                hold_toggle <= ~hold_toggle;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    ch = 8'($urandom_range(32, 255));
                else if (r < 75)
                    ch = CHAR_LF;
                else if (r < 87)
                    ch = CHAR_CR;
                else
                    ch = 8'($urandom_range(0, 31));
                send_char(ch, 1'b0, '0);
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
